@@ sv/rau_pkg.sv @@
// Shared constants, codes and control types of the rational arithmetic unit.
package rau_pkg;

  localparam int OPERAND_WIDTH = 16;
  localparam int MAG_W         = OPERAND_WIDTH + 1;
  localparam int WIDE_W        = 2 * OPERAND_WIDTH + 2;
  localparam int CNT_W         = $clog2(WIDE_W);
  localparam int SHIFT_W       = $clog2(WIDE_W + 1);
  localparam int MODE_W        = 3;
  localparam int WHOLE_W       = 32;
  localparam int REM_W         = 30;
  localparam int DEN_W         = 31;

  localparam logic [MODE_W-1:0] MODE_ADD = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_SUB = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_MUL = MODE_W'(2);
  localparam logic [MODE_W-1:0] MODE_DIV = MODE_W'(3);

  typedef enum logic [1:0] {
    MUL_CROSS_A,
    MUL_CROSS_B,
    MUL_DEN
  } mul_sel_t;

  typedef enum logic [1:0] {
    DIV_NUM,
    DIV_DEN,
    DIV_MIX
  } div_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MUL_A,
    S_MUL_B,
    S_MUL_D,
    S_SUM,
    S_GCD_INIT,
    S_GCD_STEP,
    S_GCD_END,
    S_DIVN_GO,
    S_DIVN_WAIT,
    S_DIVD_GO,
    S_DIVD_WAIT,
    S_DIVF_GO,
    S_DIVF_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     sum_en;
    logic     gcd_init;
    logic     gcd_step;
    logic     gcd_end;
    logic     div_start;
    div_sel_t div_sel;
    logic     div_wb;
    logic     out_load;
    logic     out_err;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic add_sub;
    logic gcd_done;
    logic div_done;
  } sts_t;

endpackage

@@ sv/rau_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by every division of an item.
module rau_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rau_pkg::WIDE_W-1:0]  dividend,
  input  logic [rau_pkg::WIDE_W-1:0]  divisor,
  output logic                        done,
  output logic [rau_pkg::WIDE_W-1:0]  quotient,
  output logic [rau_pkg::WIDE_W-1:0]  remainder
);

  logic [rau_pkg::WIDE_W-1:0] quo_r, quo_nxt, rem_r, rem_nxt, dvs_r;
  logic [rau_pkg::CNT_W-1:0]  cnt_r;
  logic                       busy_r, done_r;
  logic [rau_pkg::WIDE_W:0]   shifted, diff;

  always_comb begin
    shifted = {rem_r, quo_r[rau_pkg::WIDE_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    if (diff[rau_pkg::WIDE_W]) begin
      rem_nxt = shifted[rau_pkg::WIDE_W-1:0];
      quo_nxt = {quo_r[rau_pkg::WIDE_W-2:0], 1'b0};
    end else begin
      rem_nxt = diff[rau_pkg::WIDE_W-1:0];
      quo_nxt = {quo_r[rau_pkg::WIDE_W-2:0], 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= rau_pkg::CNT_W'(rau_pkg::WIDE_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

@@ sv/rau_dp.sv @@
// Datapath: operand registers, shared multiplier, binary gcd, divider and result registers.
module rau_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  rau_pkg::cmd_t                          cmd,
  output rau_pkg::sts_t                          sts,
  input  logic [rau_pkg::MODE_W-1:0]             in_mode,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] in_first_numerator,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] in_first_denominator,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] in_second_numerator,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] in_second_denominator,
  output logic                                   out_error,
  output logic                                   out_negative,
  output logic [rau_pkg::WHOLE_W-1:0]            out_whole_magnitude,
  output logic [rau_pkg::REM_W-1:0]              out_remainder_magnitude,
  output logic [rau_pkg::DEN_W-1:0]              out_denominator_magnitude
);

  localparam int MW = rau_pkg::MAG_W;
  localparam int WW = rau_pkg::WIDE_W;

  function automatic logic [MW-1:0] mag_of(input logic [rau_pkg::OPERAND_WIDTH-1:0] v);
    logic [MW-1:0] ext;
    ext = {v[rau_pkg::OPERAND_WIDTH-1], v};
    return v[rau_pkg::OPERAND_WIDTH-1] ? (MW'(0) - ext) : ext;
  endfunction

  logic [rau_pkg::MODE_W-1:0] mode_r;
  logic [MW-1:0] n1_mag_r, d1_mag_r, n2_mag_r, d2_mag_r;
  logic          n1_neg_r, d1_neg_r, n2_neg_r, d2_neg_r;
  logic [WW-1:0] num_mag_r, den_mag_r, tmp_mag_r;
  logic          num_neg_r, den_neg_r, tmp_neg_r;
  logic [WW-1:0] ga_r, gb_r, g_r;
  logic [rau_pkg::SHIFT_W-1:0] k_r;
  logic [WW-1:0] whole_r, rem_r;

  logic          out_error_r, out_negative_r;
  logic [rau_pkg::WHOLE_W-1:0] out_whole_r;
  logic [rau_pkg::REM_W-1:0]   out_rem_r;
  logic [rau_pkg::DEN_W-1:0]   out_den_r;

  logic          mode_ok, is_sub;
  logic [MW-1:0] ma, mb;
  logic          sa, sb, flip;
  logic [WW-1:0] prod;
  logic          pneg;
  logic [WW-1:0] sum_mag;
  logic          sum_neg;
  logic [WW-1:0] dvd, dvs, quo, rmd;
  logic          div_done;
  logic [WW+rau_pkg::WHOLE_W-1:0] whole_ext;
  logic [WW+rau_pkg::REM_W-1:0]   rem_ext;
  logic [WW+rau_pkg::DEN_W-1:0]   den_ext;

  assign mode_ok = (mode_r == rau_pkg::MODE_ADD) || (mode_r == rau_pkg::MODE_SUB) ||
                   (mode_r == rau_pkg::MODE_MUL) || (mode_r == rau_pkg::MODE_DIV);
  assign is_sub  = (mode_r == rau_pkg::MODE_SUB);

  assign sts.bad      = (d1_mag_r == '0) || (d2_mag_r == '0) || !mode_ok ||
                        ((mode_r == rau_pkg::MODE_DIV) && (n2_mag_r == '0));
  assign sts.add_sub  = (mode_r == rau_pkg::MODE_ADD) || is_sub;
  assign sts.gcd_done = (ga_r == '0) || (gb_r == '0);
  assign sts.div_done = div_done;

  // operand pairing per product
  always_comb begin
    ma   = n1_mag_r;
    sa   = n1_neg_r;
    mb   = d2_mag_r;
    sb   = d2_neg_r;
    flip = 1'b0;
    unique case (cmd.mul_sel)
      rau_pkg::MUL_CROSS_A: begin
        if (mode_r == rau_pkg::MODE_MUL) begin
          mb = n2_mag_r;
          sb = n2_neg_r;
        end
      end
      rau_pkg::MUL_CROSS_B: begin
        ma   = n2_mag_r;
        sa   = n2_neg_r;
        mb   = d1_mag_r;
        sb   = d1_neg_r;
        flip = is_sub;
      end
      rau_pkg::MUL_DEN: begin
        ma = d1_mag_r;
        sa = d1_neg_r;
        if (mode_r == rau_pkg::MODE_DIV) begin
          mb = n2_mag_r;
          sb = n2_neg_r;
        end
      end
      default: begin
        ma = n1_mag_r;
      end
    endcase
    prod = ma * mb;
    pneg = (prod != '0) && ((sa != sb) != flip);
  end

  // signed-magnitude sum of the two cross products
  always_comb begin
    if (num_neg_r == tmp_neg_r) begin
      sum_mag = num_mag_r + tmp_mag_r;
      sum_neg = num_neg_r;
    end else if (num_mag_r >= tmp_mag_r) begin
      sum_mag = num_mag_r - tmp_mag_r;
      sum_neg = num_neg_r;
    end else begin
      sum_mag = tmp_mag_r - num_mag_r;
      sum_neg = tmp_neg_r;
    end
    if (sum_mag == '0) begin
      sum_neg = 1'b0;
    end
  end

  always_comb begin
    unique case (cmd.div_sel)
      rau_pkg::DIV_NUM: begin
        dvd = num_mag_r;
        dvs = g_r;
      end
      rau_pkg::DIV_DEN: begin
        dvd = den_mag_r;
        dvs = g_r;
      end
      rau_pkg::DIV_MIX: begin
        dvd = num_mag_r;
        dvs = den_mag_r;
      end
      default: begin
        dvd = num_mag_r;
        dvs = den_mag_r;
      end
    endcase
  end

  rau_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (dvd),
    .divisor   (dvs),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rmd)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r   <= in_mode;
      n1_mag_r <= mag_of(in_first_numerator);
      d1_mag_r <= mag_of(in_first_denominator);
      n2_mag_r <= mag_of(in_second_numerator);
      d2_mag_r <= mag_of(in_second_denominator);
      n1_neg_r <= in_first_numerator[rau_pkg::OPERAND_WIDTH-1];
      d1_neg_r <= in_first_denominator[rau_pkg::OPERAND_WIDTH-1];
      n2_neg_r <= in_second_numerator[rau_pkg::OPERAND_WIDTH-1];
      d2_neg_r <= in_second_denominator[rau_pkg::OPERAND_WIDTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      unique case (cmd.mul_sel)
        rau_pkg::MUL_CROSS_A: begin
          num_mag_r <= prod;
          num_neg_r <= pneg;
        end
        rau_pkg::MUL_CROSS_B: begin
          tmp_mag_r <= prod;
          tmp_neg_r <= pneg;
        end
        rau_pkg::MUL_DEN: begin
          den_mag_r <= prod;
          den_neg_r <= pneg;
        end
        default: begin
          tmp_mag_r <= prod;
        end
      endcase
    end else if (cmd.sum_en) begin
      num_mag_r <= sum_mag;
      num_neg_r <= sum_neg;
    end else if (cmd.div_wb) begin
      unique case (cmd.div_sel)
        rau_pkg::DIV_NUM: num_mag_r <= quo;
        rau_pkg::DIV_DEN: den_mag_r <= quo;
        rau_pkg::DIV_MIX: begin
          whole_r <= quo;
          rem_r   <= rmd;
        end
        default: begin
          whole_r <= quo;
        end
      endcase
    end
  end

  // binary gcd: strip common twos, halve an even operand, subtract odd from odd, then restore the twos
  always_ff @(posedge clk) begin
    if (cmd.gcd_init) begin
      ga_r <= num_mag_r;
      gb_r <= den_mag_r;
      k_r  <= '0;
    end else if (cmd.gcd_step) begin
      priority if (!ga_r[0] && !gb_r[0]) begin
        ga_r <= ga_r >> 1;
        gb_r <= gb_r >> 1;
        k_r  <= k_r + 1'b1;
      end else if (!ga_r[0]) begin
        ga_r <= ga_r >> 1;
      end else if (!gb_r[0]) begin
        gb_r <= gb_r >> 1;
      end else if (ga_r >= gb_r) begin
        ga_r <= ga_r - gb_r;
      end else begin
        gb_r <= gb_r - ga_r;
      end
    end else if (cmd.gcd_end) begin
      g_r <= (ga_r | gb_r) << k_r;
    end
  end

  assign whole_ext = {{rau_pkg::WHOLE_W{1'b0}}, whole_r};
  assign rem_ext   = {{rau_pkg::REM_W{1'b0}}, rem_r};
  assign den_ext   = {{rau_pkg::DEN_W{1'b0}}, den_mag_r};

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_err) begin
        out_error_r    <= 1'b1;
        out_negative_r <= 1'b0;
        out_whole_r    <= '0;
        out_rem_r      <= '0;
        out_den_r      <= '0;
      end else begin
        out_error_r    <= 1'b0;
        out_negative_r <= (num_mag_r != '0) && (num_neg_r != den_neg_r);
        out_whole_r    <= whole_ext[rau_pkg::WHOLE_W-1:0];
        out_rem_r      <= rem_ext[rau_pkg::REM_W-1:0];
        out_den_r      <= den_ext[rau_pkg::DEN_W-1:0];
      end
    end
  end

  assign out_error                 = out_error_r;
  assign out_negative              = out_negative_r;
  assign out_whole_magnitude       = out_whole_r;
  assign out_remainder_magnitude   = out_rem_r;
  assign out_denominator_magnitude = out_den_r;

endmodule

@@ sv/rau_ctrl.sv @@
// Controller: sequences products, gcd and divisions, and owns both handshakes.
module rau_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  rau_pkg::sts_t sts,
  output rau_pkg::cmd_t cmd
);

  rau_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rau_pkg::S_IDLE:      if (in_valid) state_nxt = rau_pkg::S_CHECK;
      rau_pkg::S_CHECK:     state_nxt = sts.bad ? rau_pkg::S_DONE : rau_pkg::S_MUL_A;
      rau_pkg::S_MUL_A:     state_nxt = sts.add_sub ? rau_pkg::S_MUL_B : rau_pkg::S_MUL_D;
      rau_pkg::S_MUL_B:     state_nxt = rau_pkg::S_MUL_D;
      rau_pkg::S_MUL_D:     state_nxt = sts.add_sub ? rau_pkg::S_SUM : rau_pkg::S_GCD_INIT;
      rau_pkg::S_SUM:       state_nxt = rau_pkg::S_GCD_INIT;
      rau_pkg::S_GCD_INIT:  state_nxt = rau_pkg::S_GCD_STEP;
      rau_pkg::S_GCD_STEP:  if (sts.gcd_done) state_nxt = rau_pkg::S_GCD_END;
      rau_pkg::S_GCD_END:   state_nxt = rau_pkg::S_DIVN_GO;
      rau_pkg::S_DIVN_GO:   state_nxt = rau_pkg::S_DIVN_WAIT;
      rau_pkg::S_DIVN_WAIT: if (sts.div_done) state_nxt = rau_pkg::S_DIVD_GO;
      rau_pkg::S_DIVD_GO:   state_nxt = rau_pkg::S_DIVD_WAIT;
      rau_pkg::S_DIVD_WAIT: if (sts.div_done) state_nxt = rau_pkg::S_DIVF_GO;
      rau_pkg::S_DIVF_GO:   state_nxt = rau_pkg::S_DIVF_WAIT;
      rau_pkg::S_DIVF_WAIT: if (sts.div_done) state_nxt = rau_pkg::S_DONE;
      rau_pkg::S_DONE:      if (slot_free) state_nxt = rau_pkg::S_IDLE;
      default:              state_nxt = rau_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      rau_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      rau_pkg::S_MUL_A: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = rau_pkg::MUL_CROSS_A;
      end
      rau_pkg::S_MUL_B: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = rau_pkg::MUL_CROSS_B;
      end
      rau_pkg::S_MUL_D: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = rau_pkg::MUL_DEN;
      end
      rau_pkg::S_SUM:       cmd.sum_en   = 1'b1;
      rau_pkg::S_GCD_INIT:  cmd.gcd_init = 1'b1;
      rau_pkg::S_GCD_STEP:  cmd.gcd_step = !sts.gcd_done;
      rau_pkg::S_GCD_END:   cmd.gcd_end  = 1'b1;
      rau_pkg::S_DIVN_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = rau_pkg::DIV_NUM;
      end
      rau_pkg::S_DIVN_WAIT: begin
        cmd.div_sel = rau_pkg::DIV_NUM;
        cmd.div_wb  = sts.div_done;
      end
      rau_pkg::S_DIVD_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = rau_pkg::DIV_DEN;
      end
      rau_pkg::S_DIVD_WAIT: begin
        cmd.div_sel = rau_pkg::DIV_DEN;
        cmd.div_wb  = sts.div_done;
      end
      rau_pkg::S_DIVF_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = rau_pkg::DIV_MIX;
      end
      rau_pkg::S_DIVF_WAIT: begin
        cmd.div_sel = rau_pkg::DIV_MIX;
        cmd.div_wb  = sts.div_done;
      end
      rau_pkg::S_DONE: begin
        // hold the result until the output slot frees up
        cmd.out_load = slot_free;
        cmd.out_err  = sts.bad;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rau_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ sv/rational_arithmetic_unit.sv @@
// Top level of the rational arithmetic unit: controller plus datapath.
//
//   channel  direction  handshake             payload
//   in_      request in in_valid / in_ready   mode, two signed fractions
//   out_     result out out_valid / out_ready error, sign, whole, remainder, denominator
//
// One request at a time. A request runs through the products, the binary gcd steps
// (fewer for small operands) and three passes through the one-bit-per-cycle divider.
// Errors go from the check straight to the result. A finished result waits in the
// output register while the next request is taken. rst_n is synchronous and clears
// the controller.
module rational_arithmetic_unit (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [rau_pkg::MODE_W-1:0]               in_mode,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] in_first_numerator,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] in_first_denominator,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] in_second_numerator,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] in_second_denominator,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic                                     out_error,
  output logic                                     out_negative,
  output logic [rau_pkg::WHOLE_W-1:0]              out_whole_magnitude,
  output logic [rau_pkg::REM_W-1:0]                out_remainder_magnitude,
  output logic [rau_pkg::DEN_W-1:0]                out_denominator_magnitude
);

  rau_pkg::cmd_t cmd;
  rau_pkg::sts_t sts;

  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rau_dp u_dp (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .cmd                       (cmd),
    .sts                       (sts),
    .in_mode                   (in_mode),
    .in_first_numerator        (in_first_numerator),
    .in_first_denominator      (in_first_denominator),
    .in_second_numerator       (in_second_numerator),
    .in_second_denominator     (in_second_denominator),
    .out_error                 (out_error),
    .out_negative              (out_negative),
    .out_whole_magnitude       (out_whole_magnitude),
    .out_remainder_magnitude   (out_remainder_magnitude),
    .out_denominator_magnitude (out_denominator_magnitude)
  );

endmodule

@@ bench/rau_result_checker.sv @@
// Request/result checker for the rational arithmetic unit: predicts each mixed number and compares.
module rau_result_checker (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  input  logic                                     in_ready,
  input  logic [rau_pkg::MODE_W-1:0]               in_mode,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] in_first_numerator,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] in_first_denominator,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] in_second_numerator,
  input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] in_second_denominator,
  input  logic                                     out_valid,
  input  logic                                     out_ready,
  input  logic                                     out_error,
  input  logic                                     out_negative,
  input  logic [rau_pkg::WHOLE_W-1:0]              out_whole_magnitude,
  input  logic [rau_pkg::REM_W-1:0]                out_remainder_magnitude,
  input  logic [rau_pkg::DEN_W-1:0]                out_denominator_magnitude,
  output int                                       mismatches,
  output int                                       outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                        error;
    logic                        negative;
    logic [rau_pkg::WHOLE_W-1:0] whole;
    logic [rau_pkg::REM_W-1:0]   rem;
    logic [rau_pkg::DEN_W-1:0]   den;
  } mixed_number_t;

  mixed_number_t mixed_numbers_due[$];
  int            fail_total = 0;
  int            waiting    = 0;

  assign mismatches  = fail_total;
  assign outstanding = waiting;

  function automatic mixed_number_t mixed_result_of(
    logic [rau_pkg::MODE_W-1:0] op,
    logic signed [rau_pkg::OPERAND_WIDTH-1:0] an, ad, bn, bd
  );
    mixed_number_t   r;
    longint          num, den;
    longint unsigned nm, dm, a, b, t;
    r       = '0;
    r.error = 1'b1;
    if (ad == 0 || bd == 0) return r;
    case (op)
      rau_pkg::MODE_ADD: begin
        num = longint'(an) * longint'(bd) + longint'(bn) * longint'(ad);
        den = longint'(ad) * longint'(bd);
      end
      rau_pkg::MODE_SUB: begin
        num = longint'(an) * longint'(bd) - longint'(bn) * longint'(ad);
        den = longint'(ad) * longint'(bd);
      end
      rau_pkg::MODE_MUL: begin
        num = longint'(an) * longint'(bn);
        den = longint'(ad) * longint'(bd);
      end
      rau_pkg::MODE_DIV: begin
        if (bn == 0) return r;
        num = longint'(an) * longint'(bd);
        den = longint'(ad) * longint'(bn);
      end
      default: return r;
    endcase
    nm = (num < 0) ? -num : num;
    dm = (den < 0) ? -den : den;
    a  = nm;
    b  = dm;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    if (a == 0) a = 1;
    nm = nm / a;
    dm = dm / a;
    r.error    = 1'b0;
    r.negative = (nm != 0) && ((num < 0) != (den < 0));
    r.whole    = rau_pkg::WHOLE_W'(nm / dm);
    r.rem      = rau_pkg::REM_W'(nm % dm);
    r.den      = rau_pkg::DEN_W'(dm);
    return r;
  endfunction

  task automatic check_field(string field, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      fail_total++;
    end
  endtask

  always @(posedge clk) begin
    mixed_number_t want;
    if (rst_n) begin
      // retire the result first: a request taken at the same edge is always newer
      if (out_valid && out_ready) begin
        if (mixed_numbers_due.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual err=%0b neg=%0b %0d %0d/%0d",
                   $time, out_error, out_negative, out_whole_magnitude,
                   out_remainder_magnitude, out_denominator_magnitude);
          fail_total++;
        end else begin
          want = mixed_numbers_due.pop_front();
          check_field("error", want.error, out_error);
          check_field("negative", want.negative, out_negative);
          check_field("whole_magnitude", want.whole, out_whole_magnitude);
          check_field("remainder_magnitude", want.rem, out_remainder_magnitude);
          check_field("denominator_magnitude", want.den, out_denominator_magnitude);
        end
      end
      if (in_valid && in_ready)
        mixed_numbers_due.push_back(mixed_result_of(in_mode, in_first_numerator,
                                                    in_first_denominator, in_second_numerator,
                                                    in_second_denominator));
      waiting <= mixed_numbers_due.size();
    end
  end

endmodule

@@ bench/rational_arithmetic_unit_test.sv @@
// Top of the rational arithmetic unit bench: clock, reset, request and result traffic, verdict.
module rational_arithmetic_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [rau_pkg::OPERAND_WIDTH-1:0] operand_t;

  localparam int RANDOM_REQUESTS = 500;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int DRAIN_CYCLES    = 250;
  localparam int WATCHDOG_LIMIT  = 5000;

  logic                          clk                   = 1'b0;
  logic                          rst_n                 = 1'b0;
  logic                          in_valid              = 1'b0;
  logic                          in_ready;
  logic [rau_pkg::MODE_W-1:0]    in_mode               = rau_pkg::MODE_ADD;
  operand_t                      in_first_numerator    = '0;
  operand_t                      in_first_denominator  = '0;
  operand_t                      in_second_numerator   = '0;
  operand_t                      in_second_denominator = '0;
  logic                          out_valid;
  logic                          out_ready             = 1'b0;
  logic                          out_error;
  logic                          out_negative;
  logic [rau_pkg::WHOLE_W-1:0]   out_whole_magnitude;
  logic [rau_pkg::REM_W-1:0]     out_remainder_magnitude;
  logic [rau_pkg::DEN_W-1:0]     out_denominator_magnitude;
  int                            mismatches;
  int                            outstanding;

  int requests_sent = 0;
  int burst_left    = 0;
  int gap_len       = 0;
  int idle_cycles   = 0;
  bit held_off      = 1'b0;

  always #4 clk = ~clk;

  rational_arithmetic_unit u_top (.*);

  rau_result_checker u_checker (.*);

  // Open a gap between bursts, then hold the request until it is taken.
  task automatic send_request(logic [rau_pkg::MODE_W-1:0] m, operand_t an, operand_t ad,
                              operand_t bn, operand_t bd);
    if (burst_left == 0) begin
      gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap_len > 0) begin
        in_valid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    burst_left--;
    in_valid              <= 1'b1;
    in_mode               <= m;
    in_first_numerator    <= an;
    in_first_denominator  <= ad;
    in_second_numerator   <= bn;
    in_second_denominator <= bd;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  function automatic operand_t pick_operand();
    case ($urandom_range(0, 3))
      0: return rau_pkg::OPERAND_WIDTH'($urandom);
      1: return rau_pkg::OPERAND_WIDTH'(int'($urandom_range(0, 18)) - 9);
      2: begin
        case ($urandom_range(0, 4))
          0: return {1'b1, {(rau_pkg::OPERAND_WIDTH-1){1'b0}}};
          1: return {1'b0, {(rau_pkg::OPERAND_WIDTH-1){1'b1}}};
          2: return {1'b1, {(rau_pkg::OPERAND_WIDTH-2){1'b0}}, 1'b1};
          3: return operand_t'(1);
          default: return operand_t'(-1);
        endcase
      end
      default: return rau_pkg::OPERAND_WIDTH'(int'($urandom_range(0, 511)) - 256);
    endcase
  endfunction

  function automatic operand_t pick_denominator();
    operand_t d;
    do d = pick_operand(); while (d == 0);
    return d;
  endfunction

  initial begin
    int                         kind;
    logic [rau_pkg::MODE_W-1:0] m;
    operand_t                   an, ad, bn, bd;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(rau_pkg::MODE_ADD, 1, 2, 1, 3);
    send_request(rau_pkg::MODE_SUB, 1, 2, 1, 2);
    send_request(rau_pkg::MODE_MUL, 3, 4, -2, 3);
    send_request(rau_pkg::MODE_DIV, 7, 3, 2, 5);
    send_request(rau_pkg::MODE_ADD, -1, 2, 0, 1);
    send_request(rau_pkg::MODE_SUB, -7, 2, 1, -3);
    send_request(rau_pkg::MODE_SUB, 0, -5, 0, 7);
    send_request(rau_pkg::MODE_ADD, -32768, 1, -32768, 1);
    send_request(rau_pkg::MODE_MUL, -32768, 1, -32768, 1);
    send_request(rau_pkg::MODE_DIV, -32768, -1, 1, -32768);
    send_request(rau_pkg::MODE_MUL, 32767, -32768, 32767, -32768);
    send_request(rau_pkg::MODE_ADD, 32749, 32719, -32719, 32749);
    send_request(rau_pkg::MODE_DIV, -6, 4, -9, -12);
    send_request(rau_pkg::MODE_DIV, 32767, 1, -32768, -32768);
    send_request(rau_pkg::MODE_ADD, 5, 0, 1, 3);
    send_request(rau_pkg::MODE_MUL, 5, 3, 1, 0);
    send_request(rau_pkg::MODE_DIV, 5, 3, 0, 7);
    for (int op = rau_pkg::MODE_DIV + 1; op < 2 ** rau_pkg::MODE_W; op++)
      send_request(rau_pkg::MODE_W'(op), 1, 2, 1, 3);

    repeat (RANDOM_REQUESTS) begin
      kind = $urandom_range(0, 99);
      m    = rau_pkg::MODE_W'($urandom_range(rau_pkg::MODE_ADD, rau_pkg::MODE_DIV));
      an   = pick_operand();
      ad   = pick_denominator();
      bn   = pick_operand();
      bd   = pick_denominator();
      if (kind < 3) ad = '0;
      else if (kind < 6) bd = '0;
      else if (kind < 9) begin
        m  = rau_pkg::MODE_DIV;
        bn = '0;
      end else if (kind < 12)
        m = rau_pkg::MODE_W'($urandom_range(rau_pkg::MODE_DIV + 1, 2 ** rau_pkg::MODE_W - 1));
      send_request(m, an, ad, bn, bd);
    end
    in_valid <= 1'b0;

    // let the checker's count catch up with the last request
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("rational_arithmetic_unit_test passed");
    else
      $display("rational_arithmetic_unit_test failed");
    $finish;
  end

  initial begin
    int style;
    int span;
    do @(posedge clk); while (!rst_n);
    forever begin
      // hold off once, long enough for the block to back up into in_ready
      if (!held_off && requests_sent >= 60) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      style = $urandom_range(0, 3);
      span  = $urandom_range(10, 120);
      repeat (span) begin
        case (style)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 7) == 0);
          default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("rational_arithmetic_unit_test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

@@ rational_arithmetic_unit.f @@
sv/rau_pkg.sv
sv/rau_div.sv
sv/rau_dp.sv
sv/rau_ctrl.sv
sv/rational_arithmetic_unit.sv
bench/rau_result_checker.sv
bench/rational_arithmetic_unit_test.sv
